### design/qslerp_pkg.sv
// Shared types, constants and the arctangent table for the quaternion slerp pipeline.
package qslerp_pkg;

	localparam int WORK_BITS = 30;
	localparam int STEPS     = 30;
	localparam int SQ_W      = 61;
	localparam int CW        = 33;

	typedef logic signed [CW-1:0]   cword_t;
	typedef logic [SQ_W-1:0]        sq_word_t;
	typedef logic [WORK_BITS:0]     unit_t;

	localparam unit_t  ONE30    = unit_t'(1) << WORK_BITS;
	localparam cword_t CORDIC_K = cword_t'(652032874);

	// CORDIC rotator state
	typedef struct packed {
		cword_t x;
		cword_t y;
		cword_t z;
	} cvec_t;

	// square root remainder and partial root
	typedef struct packed {
		sq_word_t n;
		sq_word_t r;
	} sq_pair_t;

	// divider remainder and quotient bits so far
	typedef struct packed {
		unit_t                  r;
		logic [WORK_BITS-1:0]   q;
	} div_pair_t;

	// atan(2^-i) in binary angle units, pi/2 = 2^30
	function automatic cword_t atan_unit(input int unsigned i);
		cword_t v;
		case (i)
			0:  v = cword_t'(536870912);
			1:  v = cword_t'(316933406);
			2:  v = cword_t'(167458907);
			3:  v = cword_t'(85004756);
			4:  v = cword_t'(42667331);
			5:  v = cword_t'(21354465);
			6:  v = cword_t'(10679838);
			7:  v = cword_t'(5340245);
			8:  v = cword_t'(2670163);
			9:  v = cword_t'(1335087);
			10: v = cword_t'(667544);
			11: v = cword_t'(333772);
			12: v = cword_t'(166886);
			13: v = cword_t'(83443);
			14: v = cword_t'(41722);
			15: v = cword_t'(20861);
			16: v = cword_t'(10430);
			17: v = cword_t'(5215);
			18: v = cword_t'(2608);
			19: v = cword_t'(1304);
			20: v = cword_t'(652);
			21: v = cword_t'(326);
			22: v = cword_t'(163);
			23: v = cword_t'(81);
			24: v = cword_t'(41);
			25: v = cword_t'(20);
			26: v = cword_t'(10);
			27: v = cword_t'(5);
			28: v = cword_t'(3);
			29: v = cword_t'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### design/qslerp_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module qslerp_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                  clk,
	input  logic                  en,
	input  qslerp_pkg::sq_pair_t  d_i,
	output qslerp_pkg::sq_pair_t  d_o
);

	localparam qslerp_pkg::sq_word_t BIT =
		qslerp_pkg::sq_word_t'(1) << (2 * (qslerp_pkg::STEPS - STEP));

	qslerp_pkg::sq_word_t trial;
	qslerp_pkg::sq_pair_t nx;
	qslerp_pkg::sq_pair_t d_q;

	// restoring step: subtract r + bit when it fits
	always_comb begin
		trial = d_i.r + BIT;
		if (d_i.n >= trial) begin
			nx.n = d_i.n - trial;
			nx.r = (d_i.r >> 1) + BIT;
		end else begin
			nx.n = d_i.n;
			nx.r = d_i.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nx;
		end
	end

	assign d_o = d_q;

endmodule

### design/qslerp_cordic_cell.sv
// One micro-rotation of a CORDIC chain, vectoring or rotation mode.
module qslerp_cordic_cell #(
	parameter int STEP   = 0,
	parameter bit VECTOR = 1'b0
) (
	input  logic               clk,
	input  logic               en,
	input  qslerp_pkg::cvec_t  v_i,
	output qslerp_pkg::cvec_t  v_o
);

	localparam qslerp_pkg::cword_t ATAN = qslerp_pkg::atan_unit(STEP);

	qslerp_pkg::cword_t dx;
	qslerp_pkg::cword_t dy;
	logic               up;
	qslerp_pkg::cvec_t  nx;
	qslerp_pkg::cvec_t  v_q;

	// direction from y when vectoring, from z when rotating
	always_comb begin
		dx = v_i.y >>> STEP;
		dy = v_i.x >>> STEP;
		if (VECTOR) begin
			up = (v_i.y >= 0);
			if (up) begin
				nx.x = v_i.x + dx;
				nx.y = v_i.y - dy;
				nx.z = v_i.z + ATAN;
			end else begin
				nx.x = v_i.x - dx;
				nx.y = v_i.y + dy;
				nx.z = v_i.z - ATAN;
			end
		end else begin
			up = (v_i.z >= 0);
			if (up) begin
				nx.x = v_i.x - dx;
				nx.y = v_i.y + dy;
				nx.z = v_i.z - ATAN;
			end else begin
				nx.x = v_i.x + dx;
				nx.y = v_i.y - dy;
				nx.z = v_i.z + ATAN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_q <= nx;
		end
	end

	assign v_o = v_q;

endmodule

### design/qslerp_div_cell.sv
// One quotient bit of the pipelined restoring divider.
module qslerp_div_cell (
	input  logic                   clk,
	input  logic                   en,
	input  qslerp_pkg::unit_t      den,
	input  qslerp_pkg::div_pair_t  d_i,
	output qslerp_pkg::div_pair_t  d_o
);

	localparam int RW = qslerp_pkg::WORK_BITS + 1;

	logic [RW:0]            r2;
	logic [RW:0]            diff;
	logic                   fits;
	qslerp_pkg::div_pair_t  nx;
	qslerp_pkg::div_pair_t  d_q;

	// remainder stays below the divisor, so doubled it fits one more bit
	always_comb begin
		r2   = {d_i.r, 1'b0};
		diff = r2 - {1'b0, den};
		fits = (r2 >= {1'b0, den});
		nx.r = fits ? diff[RW-1:0] : r2[RW-1:0];
		nx.q = {d_i.q[qslerp_pkg::WORK_BITS-2:0], fits};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nx;
		end
	end

	assign d_o = d_q;

endmodule

### design/quaternion_slerp_top.sv
// Quaternion slerp top level: dot product, sqrt, CORDIC angle and sines, dividers, blend.
//
// Usage:
//  - Input channel in_valid/in_ready carries q1 (first_*), q2 (second_*) and fraction u.
//  - Output channel out_valid/out_ready returns out_* and the degenerate flag.
//  - cfg_wen/cfg_wdata write angle_tolerance (reset value 16); write it while idle.
//  - The chain has 131 register stages: 4 stages of dot product and magnitude, 31
//    square-root cells, 1 stage of tolerance compare, 30 vectoring CORDIC cells, 2
//    stages of angle split, 30 rotation CORDIC cells (two lanes), 31 divider stages
//    (two lanes), 2 stages of blend and saturation.
//  - Throughput is one transaction per cycle while no result is held; all cells move on en.
//  - When the receiver stalls, the result at the end of the chain moves into a skid
//    register and the chain freezes from the next cycle on; in_ready comes straight
//    from that register and stays low until the held result is taken.
//  - Reset (arst_n low) empties the pipeline and restores the tolerance register.
module quaternion_slerp_top #(
	parameter int FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] first_w,
	input  logic signed [15:0] first_x,
	input  logic signed [15:0] first_y,
	input  logic signed [15:0] first_z,
	input  logic signed [15:0] second_w,
	input  logic signed [15:0] second_x,
	input  logic signed [15:0] second_y,
	input  logic signed [15:0] second_z,
	input  logic        [14:0] fraction,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_w,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic               degenerate,
	input  logic               cfg_wen,
	input  logic        [14:0] cfg_wdata
);

	localparam int WB     = qslerp_pkg::WORK_BITS;
	localparam int NST    = qslerp_pkg::STEPS;
	localparam int DOT_SH = 2 * FRAC_BITS - WB;
	localparam int SH_R   = (DOT_SH > 0) ? DOT_SH : 0;
	localparam int SH_L   = (DOT_SH < 0) ? -DOT_SH : 0;
	localparam int TOL_SH = WB - FRAC_BITS;

	// stage indexes along the chain
	localparam int ST_DOT  = 1;
	localparam int ST_MAG  = ST_DOT + 1;
	localparam int ST_SQ0  = ST_MAG + 2;
	localparam int ST_DEG  = ST_SQ0 + NST + 1;
	localparam int ST_VEC0 = ST_DEG + 1;
	localparam int ST_TH   = ST_VEC0 + NST;
	localparam int ST_ANG  = ST_TH + 1;
	localparam int ST_ROT0 = ST_ANG + 1;
	localparam int ST_NUM  = ST_ROT0 + NST;
	localparam int ST_DIV0 = ST_NUM + 1;
	localparam int ST_MUL  = ST_DIV0 + NST;
	localparam int LAT     = ST_MUL + 2;

	typedef struct packed {
		logic [3:0][15:0]   p;
		logic [3:0][15:0]   qv;
		qslerp_pkg::unit_t  u30;
		logic               neg;
		qslerp_pkg::unit_t  a30;
		qslerp_pkg::unit_t  s30;
		logic               degen;
		logic [1:0]         c_zero;
		logic [1:0]         c_sat;
	} side_t;

	logic                en;
	logic [LAT-1:0]      vld_q;
	logic [14:0]         tol_q;

	// output skid register
	logic                skid_vld_q;
	logic signed [15:0]  skid_res_q [4];
	logic                skid_deg_q;

	side_t               side_s  [LAT];
	side_t               side_nx [LAT];

	logic signed [31:0]  prod_s1 [4];
	logic signed [33:0]  dot_s2;
	logic [61:0]         asq_s4;
	qslerp_pkg::unit_t   theta_s6;
	logic [61:0]         tu_s6;
	qslerp_pkg::cword_t  ang_s7 [2];
	qslerp_pkg::unit_t   rem_s8 [2];
	logic signed [47:0]  pa_s9 [4];
	logic signed [47:0]  pb_s9 [4];
	logic signed [15:0]  res_s10 [4];
	logic                deg_s10;

	// combinational helpers
	qslerp_pkg::unit_t   u_ext;
	qslerp_pkg::unit_t   u_one;
	qslerp_pkg::unit_t   u_cl;
	logic [32:0]         mag;
	logic [63:0]         a_full;
	qslerp_pkg::unit_t   a30_c;
	qslerp_pkg::unit_t   s30_c;
	logic [35:0]         tol30;
	logic                degen_c;
	qslerp_pkg::cword_t  num   [2];
	logic [1:0]          zero_c;
	logic [1:0]          sat_c;

	qslerp_pkg::sq_pair_t   sq_v  [NST+2];
	qslerp_pkg::cvec_t      vec_v [NST+1];
	qslerp_pkg::cvec_t      rot_v [2][NST+1];
	qslerp_pkg::div_pair_t  div_v [2][NST+1];

	// chain moves while the skid register is empty
	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// skid flag: set when the last stage would be overrun, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_q[LAT-1] && !out_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_q[LAT-1] && !out_ready) begin
			skid_res_q <= res_s10;
			skid_deg_q <= deg_s10;
		end
	end

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 15'd16;
		end else if (cfg_wen) begin
			tol_q <= cfg_wdata;
		end
	end

	// fraction clamp to 1.0; the scaling to Q30 is done in the sideband
	always_comb begin
		u_ext = qslerp_pkg::unit_t'(fraction);
		u_one = qslerp_pkg::unit_t'(1) << FRAC_BITS;
		u_cl  = (u_ext > u_one) ? u_one : u_ext;
	end

	// dot magnitude scaled to Q30 and clamped to one
	always_comb begin
		mag    = dot_s2[33] ? 33'(-dot_s2) : 33'(dot_s2);
		a_full = (64'(mag) >> SH_R) << SH_L;
		a30_c  = (a_full > 64'(qslerp_pkg::ONE30)) ? qslerp_pkg::ONE30 : a_full[WB:0];
	end

	// degenerate test on the sine
	always_comb begin
		s30_c   = sq_v[NST+1].r[WB:0];
		tol30   = 36'(tol_q) << TOL_SH;
		degen_c = (s30_c == '0) || (36'(s30_c) < tol30);
	end

	// numerator classes for each coefficient
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			num[l]    = rot_v[l][NST].y;
			zero_c[l] = (num[l] <= 0);
			sat_c[l]  = (num[l] >= $signed({2'b00, side_s[ST_NUM-1].s30}));
		end
	end

	// sideband pipeline: payload travels with its transaction
	always_comb begin
		side_nx[0]        = '0;
		side_nx[0].p      = {first_z, first_y, first_x, first_w};
		side_nx[0].qv     = {second_z, second_y, second_x, second_w};
		side_nx[0].u30    = u_cl << TOL_SH;
		for (int g = 1; g < LAT; g++) begin
			side_nx[g] = side_s[g-1];
		end
		side_nx[ST_MAG].neg    = dot_s2[33];
		side_nx[ST_MAG].a30    = a30_c;
		side_nx[ST_DEG].s30    = s30_c;
		side_nx[ST_DEG].degen  = degen_c;
		side_nx[ST_NUM].c_zero = zero_c;
		side_nx[ST_NUM].c_sat  = sat_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s <= side_nx;
		end
	end

	// products, dot sum and the square of the magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= first_w * second_w;
			prod_s1[1] <= first_x * second_x;
			prod_s1[2] <= first_y * second_y;
			prod_s1[3] <= first_z * second_z;
			dot_s2     <= 34'(prod_s1[0]) + 34'(prod_s1[1])
			            + 34'(prod_s1[2]) + 34'(prod_s1[3]);
			asq_s4     <= side_s[ST_MAG].a30 * side_s[ST_MAG].a30;
		end
	end

	// square root of one minus a squared
	assign sq_v[0].n = qslerp_pkg::sq_word_t'(62'(1) << 60) - asq_s4[60:0];
	assign sq_v[0].r = '0;

	for (genvar i = 0; i <= NST; i++) begin : g_sqrt
		qslerp_sqrt_cell #(.STEP(i)) u_cell (
			.clk (clk),
			.en  (en),
			.d_i (sq_v[i]),
			.d_o (sq_v[i+1])
		);
	end

	// angle from (a, s) by vectoring
	assign vec_v[0].x = $signed({2'b00, side_s[ST_DEG].a30});
	assign vec_v[0].y = $signed({2'b00, side_s[ST_DEG].s30});
	assign vec_v[0].z = '0;

	for (genvar i = 0; i < NST; i++) begin : g_vec
		qslerp_cordic_cell #(.STEP(i), .VECTOR(1'b1)) u_cell (
			.clk (clk),
			.en  (en),
			.v_i (vec_v[i]),
			.v_o (vec_v[i+1])
		);
	end

	// clamp theta, split by u
	always_ff @(posedge clk) begin
		qslerp_pkg::unit_t th;
		th = '0;
		if (vec_v[NST].z < 0) begin
			th = '0;
		end else if (vec_v[NST].z > $signed({2'b00, qslerp_pkg::ONE30})) begin
			th = qslerp_pkg::ONE30;
		end else begin
			th = vec_v[NST].z[WB:0];
		end
		if (en) begin
			theta_s6  <= th;
			tu_s6     <= th * side_s[ST_TH-1].u30;
			ang_s7[1] <= $signed({2'b00, tu_s6[2*WB:WB]});
			ang_s7[0] <= $signed({2'b00, theta_s6}) - $signed({2'b00, tu_s6[2*WB:WB]});
		end
	end

	// two sine lanes: lane 0 for (1-u)theta, lane 1 for u*theta
	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign rot_v[l][0].x = qslerp_pkg::CORDIC_K;
		assign rot_v[l][0].y = '0;
		assign rot_v[l][0].z = ang_s7[l];

		for (genvar i = 0; i < NST; i++) begin : g_rot
			qslerp_cordic_cell #(.STEP(i), .VECTOR(1'b0)) u_cell (
				.clk (clk),
				.en  (en),
				.v_i (rot_v[l][i]),
				.v_o (rot_v[l][i+1])
			);
		end

		// start remainder: zero when the result is forced
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s8[l] <= (zero_c[l] || sat_c[l]) ? '0 : num[l][WB:0];
			end
		end

		assign div_v[l][0].r = rem_s8[l];
		assign div_v[l][0].q = '0;

		for (genvar i = 0; i < NST; i++) begin : g_div
			qslerp_div_cell u_cell (
				.clk (clk),
				.en  (en),
				.den (side_s[ST_DIV0+i-1].s30),
				.d_i (div_v[l][i]),
				.d_o (div_v[l][i+1])
			);
		end
	end

	// coefficients and blend products
	always_ff @(posedge clk) begin
		logic signed [31:0] c [2];
		side_t              sd;
		sd = side_s[ST_MUL-1];
		for (int l = 0; l < 2; l++) begin
			if (sd.c_zero[l]) begin
				c[l] = '0;
			end else if (sd.c_sat[l]) begin
				c[l] = $signed(32'(qslerp_pkg::ONE30));
			end else begin
				c[l] = $signed(32'(div_v[l][NST].q));
			end
		end
		if (sd.neg) begin
			c[0] = -c[0];
		end
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				pa_s9[k] <= c[0] * $signed(sd.p[k]);
				pb_s9[k] <= c[1] * $signed(sd.qv[k]);
			end
		end
	end

	// round half up, saturate, pick q1 on degenerate
	always_ff @(posedge clk) begin
		logic signed [48:0] acc;
		logic signed [48:0] v;
		side_t              sd;
		logic signed [15:0] r [4];
		sd = side_s[ST_MUL];
		for (int k = 0; k < 4; k++) begin
			acc = 49'(pa_s9[k]) + 49'(pb_s9[k]) + (49'sd1 <<< (WB - 1));
			v   = acc >>> WB;
			if (v > 49'sd32767) begin
				r[k] = 16'sh7fff;
			end else if (v < -49'sd32768) begin
				r[k] = 16'sh8000;
			end else begin
				r[k] = v[15:0];
			end
			if (sd.degen) begin
				r[k] = $signed(sd.p[k]);
			end
		end
		if (en) begin
			res_s10 <= r;
			deg_s10 <= sd.degen;
		end
	end

	// held result goes out first, the frozen last stage follows
	assign out_valid  = skid_vld_q || vld_q[LAT-1];
	assign out_w      = skid_vld_q ? skid_res_q[0] : res_s10[0];
	assign out_x      = skid_vld_q ? skid_res_q[1] : res_s10[1];
	assign out_y      = skid_vld_q ? skid_res_q[2] : res_s10[2];
	assign out_z      = skid_vld_q ? skid_res_q[3] : res_s10[3];
	assign degenerate = skid_vld_q ? skid_deg_q : deg_s10;

endmodule

### design/qslerp_chk.sv
// Port-level checker for the quaternion slerp block, bound to the top level.
module qslerp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] out_w,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y,
	input logic signed [15:0] out_z,
	input logic               degenerate
);

	// input is blocked only while a result is held, and frees up once it is taken
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready |-> out_valid) and (out_valid && out_ready |=> in_ready))
		else $error("in_ready does not follow the output stall");

	// a stalled result holds its transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_w) && $stable(out_x)
			&& $stable(out_y) && $stable(out_z) && $stable(degenerate))
		else $error("stalled result changed");

	// pipeline comes out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	// handshake lines are always known out of reset
	a_known_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid, out_ready}))
		else $error("unknown handshake value");

endmodule

bind quaternion_slerp_top qslerp_chk u_qslerp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_w      (out_w),
	.out_x      (out_x),
	.out_y      (out_y),
	.out_z      (out_z),
	.degenerate (degenerate)
);

### bench/tb.sv
// Testbench for the quaternion slerp pipeline: streams quaternion pairs and checks each result.
`timescale 1ns / 1ps

module tb;

	localparam int FRAC       = 14;
	localparam int LATENCY    = 131;
	localparam int STALL_MAX  = 6;
	localparam int IDLE_LIMIT = 4000;
	localparam int N_RANDOM   = 1080;

	typedef struct {
		logic signed [15:0] a [4];
		logic signed [15:0] b [4];
		logic        [14:0] frac;
	} qpair_t;

	typedef struct {
		logic signed [15:0] c [4];
		logic               degen;
	} qblend_t;

	// Predicts slerp results and holds them until the block delivers them
	class slerp_scoreboard;
		qblend_t     pending[$];
		logic [14:0] tolerance = 15'd16;
		int          mismatches = 0;
		int          n_checked = 0;
		int          n_degen = 0;

		function longint unsigned isqrt(longint unsigned n);
			longint unsigned r = 0;
			longint unsigned bits = 64'd1 << 62;
			while (bits > n) bits >>= 2;
			while (bits != 0) begin
				if (n >= r + bits) begin
					n -= r + bits;
					r = (r >> 1) + bits;
				end else begin
					r >>= 1;
				end
				bits >>= 2;
			end
			return r;
		endfunction

		function longint arc(longint x, longint y);
			longint z = 0;
			longint dx, dy;
			for (int i = 0; i < qslerp_pkg::STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += longint'(qslerp_pkg::atan_unit(i));
				end else begin
					x -= dx; y += dy; z -= longint'(qslerp_pkg::atan_unit(i));
				end
			end
			if (z < 0) z = 0;
			if (z > (64'sd1 << qslerp_pkg::WORK_BITS)) z = 64'sd1 << qslerp_pkg::WORK_BITS;
			return z;
		endfunction

		function longint sine(longint z);
			longint x = longint'(qslerp_pkg::CORDIC_K);
			longint y = 0;
			longint dx, dy;
			for (int i = 0; i < qslerp_pkg::STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(qslerp_pkg::atan_unit(i));
				end else begin
					x += dx; y -= dy; z += longint'(qslerp_pkg::atan_unit(i));
				end
			end
			return y;
		endfunction

		function longint coeff(longint num, longint unsigned den);
			longint unsigned q;
			if (num <= 0) return 0;
			q = (longint'(num) << qslerp_pkg::WORK_BITS) / den;
			if (q > (64'd1 << qslerp_pkg::WORK_BITS)) q = 64'd1 << qslerp_pkg::WORK_BITS;
			return longint'(q);
		endfunction

		// record an accepted input transaction and queue its expected result
		function void note_input(qpair_t it);
			qblend_t         r;
			longint          dot = 0, theta, ang2, c1, c2, v;
			longint unsigned mag, a30, s30, tol30, u;
			logic            neg;
			for (int k = 0; k < 4; k++) dot += longint'(it.a[k]) * longint'(it.b[k]);
			neg = dot < 0;
			mag = neg ? -dot : dot;
			a30 = mag << (qslerp_pkg::WORK_BITS - 2 * FRAC);
			if (a30 > (64'd1 << qslerp_pkg::WORK_BITS)) a30 = 64'd1 << qslerp_pkg::WORK_BITS;
			s30 = isqrt((64'd1 << 60) - a30 * a30);
			tol30 = longint'(tolerance) << (qslerp_pkg::WORK_BITS - FRAC);
			if (s30 == 0 || s30 < tol30) begin
				r.c = it.a;
				r.degen = 1'b1;
			end else begin
				theta = arc(a30, s30);
				u = it.frac;
				if (u > (64'd1 << FRAC)) u = 64'd1 << FRAC;
				ang2 = (theta * longint'(u << (qslerp_pkg::WORK_BITS - FRAC)))
					>>> qslerp_pkg::WORK_BITS;
				c1 = coeff(sine(theta - ang2), s30);
				c2 = coeff(sine(ang2), s30);
				if (neg) c1 = -c1;
				for (int k = 0; k < 4; k++) begin
					v = (c1 * it.a[k] + c2 * it.b[k]
						+ (64'sd1 << (qslerp_pkg::WORK_BITS - 1))) >>> qslerp_pkg::WORK_BITS;
					if (v > 32767) v = 32767;
					if (v < -32768) v = -32768;
					r.c[k] = v[15:0];
				end
				r.degen = 1'b0;
			end
			pending.push_back(r);
		endfunction

		// compare one delivered result with the oldest expectation
		function void check_result(qblend_t got);
			qblend_t exp_r;
			logic    bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result w=%0d x=%0d y=%0d z=%0d degen=%0b",
						got.c[0], got.c[1], got.c[2], got.c[3], got.degen);
				return;
			end
			exp_r = pending.pop_front();
			n_checked++;
			if (exp_r.degen) n_degen++;
			bad = (got.degen !== exp_r.degen);
			for (int k = 0; k < 4; k++) if (got.c[k] !== exp_r.c[k]) bad = 1'b1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d exp %0d %0d %0d %0d/%0b got %0d %0d %0d %0d/%0b",
						n_checked, exp_r.c[0], exp_r.c[1], exp_r.c[2], exp_r.c[3], exp_r.degen,
						got.c[0], got.c[1], got.c[2], got.c[3], got.degen);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] first_w, first_x, first_y, first_z;
	logic signed [15:0] second_w, second_x, second_y, second_z;
	logic        [14:0] fraction;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] out_w, out_x, out_y, out_z;
	logic               degenerate;
	logic               cfg_wen;
	logic        [14:0] cfg_wdata;

	slerp_scoreboard sb;
	bit              no_idle = 0;
	int              idle_cycles = 0;
	int              n_sent = 0;

	quaternion_slerp_top #(.FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_w(first_w), .first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_w(second_w), .second_x(second_x), .second_y(second_y), .second_z(second_z),
		.fraction(fraction),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.degenerate(degenerate),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// one input transaction, with a random gap ahead of it
	task automatic send_pair(input qpair_t it);
		int  gap;
		bit  hit;
		gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_w <= it.a[0]; first_x <= it.a[1]; first_y <= it.a[2]; first_z <= it.a[3];
		second_w <= it.b[0]; second_x <= it.b[1]; second_y <= it.b[2]; second_z <= it.b[3];
		fraction <= it.frac;
		do begin
			@(negedge clk);
			hit = in_ready;
			@(posedge clk);
		end while (!hit);
		sb.note_input(it);
		n_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [14:0] val);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.tolerance = val;
	endtask

	function automatic qpair_t make_pair(input logic signed [15:0] a0, a1, a2, a3,
			input logic signed [15:0] b0, b1, b2, b3, input logic [14:0] u);
		qpair_t p;
		p.a = '{a0, a1, a2, a3};
		p.b = '{b0, b1, b2, b3};
		p.frac = u;
		return p;
	endfunction

	// roughly unit quaternion with random direction
	function automatic void unit_quat(output logic signed [15:0] q [4]);
		real c [4];
		real n;
		do begin
			n = 0.0;
			for (int k = 0; k < 4; k++) begin
				c[k] = real'(int'($urandom_range(0, 32000)) - 16000);
				n += c[k] * c[k];
			end
		end while (n < 1.0e6);
		n = $sqrt(n);
		for (int k = 0; k < 4; k++) q[k] = 16'($rtoi(c[k] / n * 16384.0));
	endfunction

	function automatic qpair_t random_pair();
		qpair_t p;
		int     mode;
		int     spread;
		mode = $urandom_range(0, 9);
		p.frac = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
		if (mode < 2) begin
			// noise: any bit pattern
			for (int k = 0; k < 4; k++) begin
				p.a[k] = 16'($urandom);
				p.b[k] = 16'($urandom);
			end
		end else begin
			unit_quat(p.a);
			if (mode < 6) begin
				unit_quat(p.b);
			end else begin
				// near or opposite q1: small angles and the shortest-path flip
				spread = (mode == 9) ? 8 : 600;
				for (int k = 0; k < 4; k++)
					p.b[k] = 16'(p.a[k] + int'($urandom_range(0, 2 * spread)) - spread);
				if (mode >= 8)
					for (int k = 0; k < 4; k++) p.b[k] = -p.b[k];
			end
		end
		return p;
	endfunction

	// result side: random stall before each result
	initial begin : drain_results
		qblend_t got;
		int      stall;
		bit      hit;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, STALL_MAX);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				hit = out_valid && out_ready;
				got.c = '{out_w, out_x, out_y, out_z};
				got.degen = degenerate;
				@(posedge clk);
			end while (!hit);
			sb.check_result(got);
		end
	end

	// watchdog on cycles with no transaction
	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// main sequence
	initial begin : stimulus
		qpair_t       dir [$];
		logic [14:0]  tol_set [$];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		fraction = '0;
		{first_w, first_x, first_y, first_z} = '0;
		{second_w, second_x, second_y, second_z} = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at the reset tolerance
		dir.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 8192));
		dir.push_back(make_pair(16384, 0, 0, 0, -16384, 0, 0, 0, 8192));
		dir.push_back(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
		dir.push_back(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
		dir.push_back(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 8192));
		dir.push_back(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 32767));
		dir.push_back(make_pair(16384, 0, 0, 0, 11585, 11585, 0, 0, 5000));
		dir.push_back(make_pair(16384, 0, 0, 0, -11585, 11585, 0, 0, 5000));
		dir.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 100));
		dir.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			16384));
		dir.push_back(make_pair(-32768, 32767, 0, 0, 0, 0, -32768, 32767, 12000));
		dir.push_back(make_pair(32767, 0, 0, 0, 0, 0, 0, -32768, 16384));
		dir.push_back(make_pair(16384, 0, 0, 0, 16383, 180, 0, 0, 8192));
		dir.push_back(make_pair(0, 0, 16384, 0, 0, 0, 0, 16384, 1));
		dir.push_back(make_pair(8192, 8192, 8192, 8192, 8192, -8192, 8192, -8192, 16383));
		foreach (dir[i]) send_pair(dir[i]);

		// tolerance extremes, each with a few directed items
		tol_set = '{15'd0, 15'd16384, 15'd32767, 15'd1};
		foreach (tol_set[t]) begin
			write_tolerance(tol_set[t]);
			send_pair(dir[0]);
			send_pair(dir[1]);
			send_pair(dir[5]);
			send_pair(dir[13]);
		end

		// random phases across tolerance settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_tolerance(15'd16);
				1: write_tolerance(15'd0);
				2: write_tolerance(15'd800);
				3: write_tolerance(15'($urandom_range(0, 4000)));
				4: write_tolerance(15'd16384);
				default: write_tolerance(15'd40);
			endcase
			no_idle = (ph == 2);
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				if (ph == 1 && i == 60) wait_drained();
				send_pair(random_pair());
			end
		end
		no_idle = 0;

		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		$display("Sent %0d quaternion pairs; %0d results checked, %0d of them degenerate.",
			n_sent, sb.n_checked, sb.n_degen);
		$display("Covered tolerance extremes, shortest-path flips, clamped dots and fraction > 1.");
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Mismatches: %0d, left over: %0d", sb.mismatches, sb.pending.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
design/qslerp_pkg.sv
design/qslerp_sqrt_cell.sv
design/qslerp_cordic_cell.sv
design/qslerp_div_cell.sv
design/quaternion_slerp_top.sv
design/qslerp_chk.sv
bench/tb.sv
